@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: never condition seen");

// ante at an edge implies cons through the non-overlapping implication (|=>)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// ante implies cons at the same edge
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`endif

@@ hdl/tbpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpg_pkg
// Shared types and constants of the tile background pixel generator.
// ----------------------------------------------------------------------------
package tbpg_pkg;

	localparam int VramAw    = 14;
	localparam int VramDepth = 1 << VramAw;
	localparam int CfgIdxW   = 3;

	localparam logic [3:0] UNIMPL_COLOR = 4'd8;

	// item kinds on the request channel
	localparam logic ITEM_RENDER = 1'b0;
	localparam logic ITEM_WRITE  = 1'b1;

	// video modes that render patterns
	localparam logic [2:0] VMODE_G1 = 3'd0;
	localparam logic [2:0] VMODE_G2 = 3'd2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_DISPLAY_ON     = 3'd0,
		CFG_VIDEO_MODE     = 3'd1,
		CFG_BACKDROP_COLOR = 3'd2,
		CFG_NAME_BASE      = 3'd3,
		CFG_PATTERN_BASE   = 3'd4,
		CFG_COLOR_BASE     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic       display_on;
		logic [2:0] video_mode;
		logic [3:0] backdrop_color;
		logic [3:0] name_base;
		logic [2:0] pattern_base;
		logic [7:0] color_base;
	} cfg_t;

	// read requests towards the video memory
	typedef struct packed {
		logic              a_en;
		logic [VramAw-1:0] a_addr;
		logic              b_en;
		logic [VramAw-1:0] b_addr;
	} rd_req_t;

	// byte write towards the video memory
	typedef struct packed {
		logic              en;
		logic [VramAw-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

endpackage

@@ hdl/tbpg_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpg_cfg
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module tbpg_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [tbpg_pkg::CfgIdxW-1:0] wr_index,
	input  logic [7:0]                   wr_data,
	output tbpg_pkg::cfg_t               cfg
);

	tbpg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (tbpg_pkg::cfg_idx_t'(wr_index))
				tbpg_pkg::CFG_DISPLAY_ON:     cfg_q.display_on     <= wr_data[0];
				tbpg_pkg::CFG_VIDEO_MODE:     cfg_q.video_mode     <= wr_data[2:0];
				tbpg_pkg::CFG_BACKDROP_COLOR: cfg_q.backdrop_color <= wr_data[3:0];
				tbpg_pkg::CFG_NAME_BASE:      cfg_q.name_base      <= wr_data[3:0];
				tbpg_pkg::CFG_PATTERN_BASE:   cfg_q.pattern_base   <= wr_data[2:0];
				tbpg_pkg::CFG_COLOR_BASE:     cfg_q.color_base     <= wr_data;
				default: ; // unknown index: dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/tbpg_addr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpg_addr
// VRAM address forming for name, pattern and colour table reads.
// ----------------------------------------------------------------------------
module tbpg_addr (
	input  tbpg_pkg::cfg_t                    cfg,
	input  logic [7:0]                        name_x,
	input  logic [7:0]                        name_y,
	input  logic [7:0]                        name_byte,
	input  logic [7:0]                        row_y,
	output logic [tbpg_pkg::VramAw-1:0]       name_addr,
	output logic [tbpg_pkg::VramAw-1:0]       pat_addr,
	output logic [tbpg_pkg::VramAw-1:0]       col_addr
);

	logic        third1;
	logic        third2;
	logic [12:0] low_g2;

	assign name_addr = {cfg.name_base, name_y[7:3], name_x[7:3]};

	// graphics two: screen thirds pick bits 12..11, bottom band keeps them 0
	assign third1 = (row_y[7:6] == 2'b01);
	assign third2 = (row_y[7:6] == 2'b10);
	assign low_g2 = {cfg.pattern_base[1] & third2, cfg.pattern_base[0] & third1,
		name_byte, row_y[2:0]};

	always_comb begin
		if (cfg.video_mode == tbpg_pkg::VMODE_G2) begin
			pat_addr = {cfg.pattern_base[2], low_g2};
			col_addr = {cfg.color_base[7], low_g2};
		end else begin
			pat_addr = {cfg.pattern_base, name_byte, row_y[2:0]};
			col_addr = {cfg.color_base, 1'b0, name_byte[7:3]};
		end
	end

endmodule

@@ hdl/tbpg_vram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpg_vram
// 16 KiB video memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tbpg_vram (
	input  logic              clk,
	input  tbpg_pkg::wr_req_t wr,
	input  tbpg_pkg::rd_req_t rd,
	output logic [7:0]        a_data,
	output logic [7:0]        b_data
);

	logic [7:0] mem [tbpg_pkg::VramDepth];
	logic [7:0] a_q;
	logic [7:0] b_q;

	// read-before-write on a same-edge collision
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.a_en) begin
			a_q <= mem[rd.a_addr];
		end
		if (rd.b_en) begin
			b_q <= mem[rd.b_addr];
		end
	end

	assign a_data = a_q;
	assign b_data = b_q;

endmodule

@@ hdl/tile_background_pixel_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_background_pixel_generator_unit
// Tile background pixel generator: VRAM byte writes and 4-bit pixel lookups.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid / req_stall): mode 1 writes mem_data at
//    mem_address and gives no result; mode 0 renders the pixel at
//    pixel_x, pixel_y and gives one pixel_color transfer.
//  - Response channel (rsp_valid / rsp_stall): one transfer per render, in
//    request order.
//  - Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): always
//    ready; write only while no render is outstanding.
//  - A render passes through stage 1, stage 2 and the output register.
//  - Requests stall while a render sits in stage 1. The name read uses read
//    port A at the accepting edge; the pattern and colour reads use both
//    ports at the next edge, during which req_stall is high.
//  - Writes commit at the accepting edge, so later renders see them and
//    earlier ones do not.
//  - Reset clears the pipeline valid bits and the configuration registers,
//    not the pipeline data; VRAM content is undefined until written.
//  - A stalled response holds in the output register; the render behind it
//    waits in stage 2 and further requests stall until it moves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tile_background_pixel_generator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         mode,
	input  logic [7:0]                   pixel_x,
	input  logic [7:0]                   pixel_y,
	input  logic [tbpg_pkg::VramAw-1:0]  mem_address,
	input  logic [7:0]                   mem_data,
	// response channel
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [3:0]                   pixel_color,
	// configuration channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tbpg_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [7:0]                   cfg_data
);

	tbpg_pkg::cfg_t    cfg;
	tbpg_pkg::rd_req_t rd;
	tbpg_pkg::wr_req_t wr;

	logic [tbpg_pkg::VramAw-1:0] name_addr;
	logic [tbpg_pkg::VramAw-1:0] pat_addr;
	logic [tbpg_pkg::VramAw-1:0] col_addr;
	logic [7:0]                  a_data;
	logic [7:0]                  b_data;

	// stage 1: name byte in flight
	logic       valid_s1;
	logic [7:0] y_s1;
	logic [2:0] xl_s1;
	logic       fixed_s1;
	logic [3:0] fcolor_s1;
	// stage 2: pattern and colour bytes in flight
	logic       valid_s2;
	logic [2:0] xl_s2;
	logic       fixed_s2;
	logic [3:0] fcolor_s2;
	// output register
	logic       rsp_valid_q;
	logic [3:0] pixel_color_q;

	logic       req_xfer;
	logic       render_xfer;
	logic       out_free;
	logic       adv_s2;
	logic       fixed_now;
	logic [3:0] fcolor_now;
	logic       pat_bit;
	logic [3:0] color_s2;

	// ---------------------------------------------------------------- control
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign adv_s2    = valid_s2 && out_free;
	// stage 1 owns port A's data register; stage 2 must leave when a new
	// name read lands, as both share that register
	assign req_stall = valid_s1 || (valid_s2 && !out_free);
	assign req_xfer  = req_valid && !req_stall;
	assign render_xfer = req_xfer && (mode == tbpg_pkg::ITEM_RENDER);

	// display off and unsupported modes ignore the table lookups and give a fixed colour
	always_comb begin
		if (!cfg.display_on) begin
			fixed_now  = 1'b1;
			fcolor_now = cfg.backdrop_color;
		end else if (cfg.video_mode != tbpg_pkg::VMODE_G1 &&
				cfg.video_mode != tbpg_pkg::VMODE_G2) begin
			fixed_now  = 1'b1;
			fcolor_now = tbpg_pkg::UNIMPL_COLOR;
		end else begin
			fixed_now  = 1'b0;
			fcolor_now = cfg.backdrop_color;
		end
	end

	// ---------------------------------------------------------------- VRAM ports
	assign wr.en   = req_xfer && (mode == tbpg_pkg::ITEM_WRITE);
	assign wr.addr = mem_address;
	assign wr.data = mem_data;

	// port A: name read on accept, pattern read when stage 1 moves on
	assign rd.a_en   = render_xfer || valid_s1;
	assign rd.a_addr = valid_s1 ? pat_addr : name_addr;
	assign rd.b_en   = valid_s1;
	assign rd.b_addr = col_addr;

	tbpg_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tbpg_addr u_addr (
		.cfg       (cfg),
		.name_x    (pixel_x),
		.name_y    (pixel_y),
		.name_byte (a_data),
		.row_y     (y_s1),
		.name_addr (name_addr),
		.pat_addr  (pat_addr),
		.col_addr  (col_addr)
	);

	tbpg_vram u_vram (
		.clk    (clk),
		.wr     (wr),
		.rd     (rd),
		.a_data (a_data),
		.b_data (b_data)
	);

	// ---------------------------------------------------------------- pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			valid_s1 <= render_xfer;
			// stage 1 always moves on: stage 2 is empty whenever stage 1 holds
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (out_free) begin
				rsp_valid_q <= adv_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (render_xfer) begin
			y_s1      <= pixel_y;
			xl_s1     <= pixel_x[2:0];
			fixed_s1  <= fixed_now;
			fcolor_s1 <= fcolor_now;
		end
		if (valid_s1) begin
			xl_s2     <= xl_s1;
			fixed_s2  <= fixed_s1;
			fcolor_s2 <= fcolor_s1;
		end
		if (adv_s2) begin
			pixel_color_q <= color_s2;
		end
	end

	// leftmost pixel is pattern bit 7
	assign pat_bit  = a_data[~xl_s2];
	assign color_s2 = fixed_s2 ? fcolor_s2 : (pat_bit ? b_data[7:4] : b_data[3:0]);

	assign rsp_valid   = rsp_valid_q;
	assign pixel_color = pixel_color_q;
	assign cfg_ready   = 1'b1;

	// ---------------------------------------------------------------- checks
	`ASSERT_NEVER(a_stage_overlap, clk, arst_n, valid_s1 && valid_s2)
	`ASSERT_NEXT(a_s1_one_cycle, clk, arst_n, valid_s1, !valid_s1 && valid_s2)
	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, req_valid && !req_stall, !valid_s1)
	`ASSERT_NEXT(a_render_enters, clk, arst_n, render_xfer, valid_s1)

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tile background pixel generator. A queue of
// VRAM writes and pixel renders is replayed under random sender gaps and
// receiver stalls. Each accepted render is priced against a bit-true colour
// predictor, and the response stream is compared in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 1000;   // cycles with no transfer on any channel
	localparam int RANDOM_PHASES  = 9;
	localparam int PHASE_ITEMS    = 190;
	localparam int SETTLE_CYCLES  = 6;      // writes give nothing back
	localparam int MAX_WAIT       = 16;

	// register indexes the block has no register for
	localparam logic [tbpg_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [tbpg_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

	typedef logic [tbpg_pkg::VramAw-1:0] vaddr_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] x;
		logic [7:0] y;
		vaddr_t     addr;
		logic [7:0] data;
	} vdp_job_t;

	typedef struct packed {
		logic [3:0] color;
		logic [7:0] x;
		logic [7:0] y;
	} pixel_expect_t;

	// ports
	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         req_valid   = 1'b0;
	logic                         req_stall;
	logic                         mode        = tbpg_pkg::ITEM_RENDER;
	logic [7:0]                   pixel_x     = '0;
	logic [7:0]                   pixel_y     = '0;
	vaddr_t                       mem_address = '0;
	logic [7:0]                   mem_data    = '0;
	logic                         rsp_valid;
	logic                         rsp_stall   = 1'b0;
	logic [3:0]                   pixel_color;
	logic                         cfg_valid   = 1'b0;
	logic                         cfg_ready;
	logic [tbpg_pkg::CfgIdxW-1:0] cfg_index   = tbpg_pkg::CFG_DISPLAY_ON;
	logic [7:0]                   cfg_data    = '0;

	// predictor state, updated at each accepted transfer
	tbpg_pkg::cfg_t shadow_cfg = '0;
	logic [7:0]     vram_model [tbpg_pkg::VramDepth];
	pixel_expect_t  expected_pixels[$];

	// planning view of the VRAM: what the queued jobs will have written
	logic [7:0]    vram_plan [tbpg_pkg::VramDepth];
	bit            vram_planned [tbpg_pkg::VramDepth];
	vdp_job_t      vdp_jobs[$];

	vdp_job_t      next_job;
	pixel_expect_t want;
	logic [7:0]    band_rows [8] = '{8'd0, 8'd63, 8'd64, 8'd127, 8'd128, 8'd191, 8'd192, 8'd255};
	int            fail_count   = 0;
	int            req_gap_max  = 0;
	int            rsp_gap_max  = 0;
	int            gap_left     = 0;
	int            stall_left   = 0;
	int            quiet_cycles = 0;
	bit            req_taken    = 1'b0;

	tile_background_pixel_generator_unit DUT (.*);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------
	function automatic int draw_wait(int max_wait);
		if (max_wait == 0 || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, max_wait);
	endfunction

	function automatic vaddr_t name_addr(tbpg_pkg::cfg_t c, logic [7:0] x, logic [7:0] y);
		return {c.name_base, y[7:3], x[7:3]};
	endfunction

	// pattern and colour byte addresses for a name byte on row y
	function automatic void tile_addrs(input tbpg_pkg::cfg_t c, input logic [7:0] nm,
			input logic [7:0] y, output vaddr_t pat_a, output vaddr_t col_a);
		logic [12:0] low;
		if (c.video_mode == tbpg_pkg::VMODE_G1) begin
			pat_a = {c.pattern_base, nm, y[2:0]};
			col_a = {c.color_base, 1'b0, nm[7:3]};
		end else begin
			// graphics two: screen third picks the table bank, bottom band uses bank 0
			low = {2'b00, nm, y[2:0]};
			if (y >= 64 && y <= 127)
				low[11] = c.pattern_base[0];
			if (y >= 128 && y <= 191)
				low[12] = c.pattern_base[1];
			pat_a = {c.pattern_base[2], low};
			col_a = {c.color_base[7], low};
		end
	endfunction

	function automatic bit renders_tiles(tbpg_pkg::cfg_t c);
		return c.display_on && (c.video_mode == tbpg_pkg::VMODE_G1 ||
			c.video_mode == tbpg_pkg::VMODE_G2);
	endfunction

	function automatic logic [3:0] predict_color(logic [7:0] x, logic [7:0] y);
		logic [7:0] nm;
		logic [7:0] pat;
		logic [7:0] col;
		vaddr_t     pat_a;
		vaddr_t     col_a;
		if (!shadow_cfg.display_on)
			return shadow_cfg.backdrop_color;
		if (!renders_tiles(shadow_cfg))
			return tbpg_pkg::UNIMPL_COLOR;
		nm = vram_model[name_addr(shadow_cfg, x, y)];
		tile_addrs(shadow_cfg, nm, y, pat_a, col_a);
		pat = vram_model[pat_a];
		col = vram_model[col_a];
		// leftmost pixel of the tile is pattern bit 7
		return pat[~x[2:0]] ? col[7:4] : col[3:0];
	endfunction

	function automatic void apply_reg(logic [tbpg_pkg::CfgIdxW-1:0] idx, logic [7:0] d);
		case (idx)
			tbpg_pkg::CFG_DISPLAY_ON:     shadow_cfg.display_on     = d[0];
			tbpg_pkg::CFG_VIDEO_MODE:     shadow_cfg.video_mode     = d[2:0];
			tbpg_pkg::CFG_BACKDROP_COLOR: shadow_cfg.backdrop_color = d[3:0];
			tbpg_pkg::CFG_NAME_BASE:      shadow_cfg.name_base      = d[3:0];
			tbpg_pkg::CFG_PATTERN_BASE:   shadow_cfg.pattern_base   = d[2:0];
			tbpg_pkg::CFG_COLOR_BASE:     shadow_cfg.color_base     = d;
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		fail_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// job planning (zero time, fills the driver queue)
	// ------------------------------------------------------------------
	function automatic void plan_write(vaddr_t a, logic [7:0] d);
		vdp_job_t j;
		j.mode = tbpg_pkg::ITEM_WRITE;
		j.x    = 8'($urandom);
		j.y    = 8'($urandom);
		j.addr = a;
		j.data = d;
		vram_plan[a]    = d;
		vram_planned[a] = 1'b1;
		vdp_jobs.push_back(j);
	endfunction

	function automatic void plan_fill(vaddr_t a);
		if (!vram_planned[a])
			plan_write(a, 8'($urandom));
	endfunction

	// every byte a render will look at is written beforehand
	function automatic void plan_render(logic [7:0] x, logic [7:0] y);
		vdp_job_t j;
		vaddr_t   na;
		vaddr_t   pat_a;
		vaddr_t   col_a;
		if (renders_tiles(shadow_cfg)) begin
			na = name_addr(shadow_cfg, x, y);
			plan_fill(na);
			tile_addrs(shadow_cfg, vram_plan[na], y, pat_a, col_a);
			plan_fill(pat_a);
			plan_fill(col_a);
		end
		j.mode = tbpg_pkg::ITEM_RENDER;
		j.x    = x;
		j.y    = y;
		j.addr = vaddr_t'($urandom_range(0, tbpg_pkg::VramDepth - 1));
		j.data = 8'($urandom);
		vdp_jobs.push_back(j);
	endfunction

	// rewrite one tile's name, pattern and colour, then render pixels of that row
	function automatic void plan_retile(logic [7:0] x, logic [7:0] y);
		vaddr_t     na;
		vaddr_t     pat_a;
		vaddr_t     col_a;
		logic [7:0] nm;
		int         n;
		na = name_addr(shadow_cfg, x, y);
		nm = 8'($urandom);
		plan_write(na, nm);
		tile_addrs(shadow_cfg, nm, y, pat_a, col_a);
		plan_write(pat_a, 8'($urandom));
		plan_write(col_a, 8'($urandom));
		n = $urandom_range(1, 3);
		repeat (n)
			plan_render({x[7:3], 3'($urandom)}, y);
	endfunction

	function automatic logic [7:0] pick_edge(logic [7:0] hi);
		case ($urandom_range(0, 3))
			0:       return 8'd0;
			1:       return hi;
			default: return 8'($urandom_range(0, hi));
		endcase
	endfunction

	function automatic tbpg_pkg::cfg_t make_cfg(logic on, logic [2:0] vm, logic [3:0] bd,
			logic [3:0] nb, logic [2:0] pb, logic [7:0] cb);
		tbpg_pkg::cfg_t c;
		c.display_on     = on;
		c.video_mode     = vm;
		c.backdrop_color = bd;
		c.name_base      = nb;
		c.pattern_base   = pb;
		c.color_base     = cb;
		return c;
	endfunction

	function automatic tbpg_pkg::cfg_t random_cfg();
		tbpg_pkg::cfg_t c;
		c.display_on = ($urandom_range(0, 5) != 0);
		case ($urandom_range(0, 4))
			0, 1:    c.video_mode = tbpg_pkg::VMODE_G1;
			2, 3:    c.video_mode = tbpg_pkg::VMODE_G2;
			default: c.video_mode = 3'($urandom);
		endcase
		c.backdrop_color = 4'(pick_edge(8'd15));
		c.name_base      = 4'(pick_edge(8'd15));
		c.pattern_base   = 3'(pick_edge(8'd7));
		c.color_base     = pick_edge(8'd255);
		return c;
	endfunction

	// ------------------------------------------------------------------
	// configuration writes, only ever issued while the block is idle
	// ------------------------------------------------------------------
	task automatic program_reg(logic [tbpg_pkg::CfgIdxW-1:0] idx, logic [7:0] value,
			int width);
		logic [7:0] junk;
		logic [7:0] sent;
		junk = 8'($urandom);
		// spare upper bits carry noise; the register keeps only its width
		sent = (width >= 8) ? value : (value | (junk << width));
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= sent;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, sent);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(tbpg_pkg::cfg_t c);
		program_reg(tbpg_pkg::CFG_DISPLAY_ON, 8'(c.display_on), 1);
		program_reg(tbpg_pkg::CFG_VIDEO_MODE, 8'(c.video_mode), 3);
		program_reg(tbpg_pkg::CFG_BACKDROP_COLOR, 8'(c.backdrop_color), 4);
		if ($urandom_range(0, 2) == 0)
			program_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 8'($urandom), 8);
		program_reg(tbpg_pkg::CFG_NAME_BASE, 8'(c.name_base), 4);
		program_reg(tbpg_pkg::CFG_PATTERN_BASE, 8'(c.pattern_base), 3);
		program_reg(tbpg_pkg::CFG_COLOR_BASE, c.color_base, 8);
	endtask

	// idle = nothing queued, nothing on the request port, no pixel outstanding
	task automatic wait_idle();
		do
			@(posedge clk);
		while (vdp_jobs.size() != 0 || req_valid || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		tbpg_pkg::cfg_t c;
		int             pick;
		logic [7:0]     px;
		logic [7:0]     py;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: display off, backdrop 0; VRAM address extremes
		req_gap_max = 2;
		rsp_gap_max = 2;
		plan_write('1, 8'hFF);
		plan_write('0, 8'h00);
		plan_render(8'd0, 8'd0);
		plan_render(8'd255, 8'd255);
		wait_idle();

		// graphics one, every base at its top
		configure(make_cfg(1'b1, tbpg_pkg::VMODE_G1, 4'd15, 4'd15, 3'd7, 8'd255));
		plan_render(8'd0, 8'd0);
		plan_render(8'd255, 8'd255);
		plan_render(8'd7, 8'd8);
		plan_render(8'd248, 8'd7);
		wait_idle();

		// graphics two across the screen-third boundaries and the bottom band
		configure(make_cfg(1'b1, tbpg_pkg::VMODE_G2, 4'd0, 4'd0, 3'd7, 8'd255));
		foreach (band_rows[i])
			plan_render(8'($urandom), band_rows[i]);
		wait_idle();

		// modes without a renderer give the fixed colour
		for (int m = 1; m < 8; m++) begin
			if (3'(m) != tbpg_pkg::VMODE_G2) begin
				program_reg(tbpg_pkg::CFG_VIDEO_MODE, 8'(m), 3);
				plan_render(8'($urandom), 8'($urandom));
				wait_idle();
			end
		end

		program_reg(tbpg_pkg::CFG_DISPLAY_ON, 8'd0, 1);
		program_reg(tbpg_pkg::CFG_BACKDROP_COLOR, 8'd15, 4);
		plan_render(8'd255, 8'd0);
		wait_idle();

		// random phases; idling pattern rotates so some phases run flat out
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0: begin req_gap_max = 0;        rsp_gap_max = 0;        end
				1: begin req_gap_max = MAX_WAIT; rsp_gap_max = MAX_WAIT; end
				2: begin req_gap_max = MAX_WAIT; rsp_gap_max = 0;        end
				default: begin req_gap_max = 0;  rsp_gap_max = MAX_WAIT; end
			endcase
			c = random_cfg();
			configure(c);
			while (vdp_jobs.size() < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				px   = 8'($urandom);
				py   = 8'($urandom);
				if (pick < 20)
					plan_write(vaddr_t'($urandom_range(0, tbpg_pkg::VramDepth - 1)),
						8'($urandom));
				else if (pick < 45 && renders_tiles(shadow_cfg))
					plan_retile(px, py);
				else
					plan_render(px, py);
			end
			wait_idle();
		end

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// request driver: drives at the falling edge, holds a stalled payload
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (vdp_jobs.size() != 0) begin
					next_job = vdp_jobs.pop_front();
					mode        <= next_job.mode;
					pixel_x     <= next_job.x;
					pixel_y     <= next_job.y;
					mem_address <= next_job.addr;
					mem_data    <= next_job.data;
					req_valid   <= 1'b1;
					gap_left    = draw_wait(req_gap_max);
				end else begin
					req_valid <= 1'b0;
				end
			end
			req_taken = 1'b0;
		end
	end

	// request transfer: writes land in the model VRAM, renders are priced now
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			req_taken = 1'b1;
			if (mode == tbpg_pkg::ITEM_WRITE)
				vram_model[mem_address] = mem_data;
			else
				expected_pixels.push_back({predict_color(pixel_x, pixel_y), pixel_x, pixel_y});
		end
	end

	// ------------------------------------------------------------------
	// response monitor and stall generator
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("pixel_color %0d with no render outstanding",
					pixel_color));
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_color !== want.color)
					report_mismatch($sformatf("pixel (%0d,%0d): pixel_color %0d, want %0d",
						want.x, want.y, pixel_color, want.color));
			end
			stall_left = draw_wait(rsp_gap_max);
		end
	end

	// the drawn stall only counts down while a pixel is actually on offer
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			if (rsp_valid)
				stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// watchdog: no transfer on any channel for too long
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR @%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/tbpg_pkg.sv
hdl/tbpg_cfg.sv
hdl/tbpg_addr.sv
hdl/tbpg_vram.sv
hdl/tile_background_pixel_generator_unit.sv
sim/tb.sv
